// ----- rtl/core/bpfa_pkg.sv -----
// Package for the bitmap page frame allocator.
// Holds field widths, default sizes, command and status codes and the controller states.
// Depends on nothing; imported by the top level.
package bpfa_pkg;

    // Default sizes of the page bitmap.
    localparam int PAGES_DEF     = 512;
    localparam int WORD_BITS_DEF = 32;

    // Field widths on the ports.
    localparam int OP_W      = 2;
    localparam int PAGE_W    = 9;
    localparam int CFG_W     = 10;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTALLED  = 2'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] FIRST_FREE_RST = 10'd0;
    localparam logic [CFG_W-1:0] INSTALLED_RST  = 10'd512;

    // Command codes.
    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BEYOND  = 2'd2,
        ST_BADFREE = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        FSM_SWEEP,
        FSM_IDLE,
        FSM_SCAN,
        FSM_PICK,
        FSM_TAKE,
        FSM_SEEK,
        FSM_FCHK,
        FSM_RESP
    } fsm_t;

endpackage

// ----- rtl/core/bitmap_page_frame_allocator.sv -----
// Top level of the bitmap page frame allocator: controller, bitmap memory, config registers.
// Depends on bpfa_pkg and bpfa_lowbit.
//
// Channel   Dir  Signals                          Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser  command and page to release
// m_        out  m_tvalid m_tready m_tdata m_tuser  status, page, free count
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// One command at a time; the bitmap sits in a one-port synchronous memory of WORDS words
// and each step makes at most one memory access. Alloc reads word by word until a word
// holds a free page, then takes the lowest one if installed; free steps to the page's word,
// reads it and sets the bit; init rewrites every word. After reset a clearing pass writes
// all WORDS words before the first command. While an earlier result is not taken, the next
// result waits in the response state; configuration writes are taken every cycle.
module bitmap_page_frame_allocator #(
    parameter int PAGES     = bpfa_pkg::PAGES_DEF,
    parameter int WORD_BITS = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata fields from bit 0: free_page[8:0], zero fill.
    input  logic [bpfa_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser fields from bit 0: opcode[1:0].
    input  logic [bpfa_pkg::OP_W-1:0]        s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata fields from bit 0: page[8:0], free_count[18:9], zero fill.
    output logic [bpfa_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser fields from bit 0: status[1:0].
    output logic [bpfa_pkg::STATUS_W-1:0]    m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpfa_pkg::CFG_W-1:0]       cfg_data
);

    import bpfa_pkg::*;

    localparam int WORDS    = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OB       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int CNT_BITS = $clog2(PAGES + 1);
    localparam int BW       = ((CNT_BITS > CFG_W) ? CNT_BITS : CFG_W) + 1;

    localparam logic [BW-1:0] PAGES_X = BW'(PAGES);
    localparam logic [BW-1:0] WB_X    = BW'(WORD_BITS);
    localparam logic [AW-1:0] LAST_W  = AW'(WORDS - 1);

    // Controller and datapath registers.
    fsm_t                  state_reg, state_next;
    logic [AW-1:0]         w_reg, w_next;
    logic [BW-1:0]         base_reg, base_next;
    logic                  sweep_init_reg, sweep_init_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_w_reg, pend_w_next;
    logic [BW-1:0]         pend_base_reg, pend_base_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [WORD_BITS-1:0]  onehot_reg, onehot_next;
    logic [OB-1:0]         idx_reg, idx_next;
    logic [PAGE_W-1:0]     fp_reg, fp_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    status_t               res_status_reg, res_status_next;
    logic [PAGE_W-1:0]     res_page_reg, res_page_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [PAGE_W-1:0]     m_page_reg, m_page_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;
    logic [CFG_W-1:0]      ffp_reg, ffp_next;
    logic [CFG_W-1:0]      inst_reg, inst_next;

    // Memory port.
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [WORD_BITS-1:0]  mem_wd;
    logic [WORD_BITS-1:0]  mem_rdata_reg;
    logic [WORD_BITS-1:0]  bitmap_mem [WORDS];

    // Helpers.
    logic [WORD_BITS-1:0]  init_mask;
    logic [CNT_BITS-1:0]   init_cnt;
    logic [WORD_BITS-1:0]  lb_onehot;
    logic [OB-1:0]         lb_idx;
    logic [BW-1:0]         take_page;
    logic [OB-1:0]         free_off;
    logic [BW-1:0]         cnt_x;
    opcode_t               in_op;

    assign s_tready  = (state_reg == FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {{(M_TDATA_W - COUNT_W - PAGE_W){1'b0}}, m_count_reg, m_page_reg};

    assign in_op     = opcode_t'(s_tuser);
    assign take_page = pend_base_reg + BW'(idx_reg);
    assign free_off  = OB'(BW'(fp_reg) - base_reg);
    assign cnt_x     = BW'(cnt_reg);
    assign init_cnt  = (BW'(ffp_reg) >= PAGES_X) ? '0 : CNT_BITS'(PAGES_X - BW'(ffp_reg));

    // Init pattern for the word at base_reg: free from first_free_page up to the last page.
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            init_mask[b] = ((base_reg + BW'(b)) >= BW'(ffp_reg)) &&
                           ((base_reg + BW'(b)) < PAGES_X);
        end
    end

    bpfa_lowbit #(
        .WORD_BITS (WORD_BITS),
        .OB        (OB)
    ) u_lowbit (
        .word   (word_reg),
        .onehot (lb_onehot),
        .idx    (lb_idx)
    );

    // Bitmap memory: one access per cycle, registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            mem_rdata_reg <= bitmap_mem[mem_addr];
        end
    end

    // Next state, memory control and result capture.
    always_comb begin
        state_next      = state_reg;
        w_next          = w_reg;
        base_next       = base_reg;
        sweep_init_next = sweep_init_reg;
        pend_next       = pend_reg;
        pend_w_next     = pend_w_reg;
        pend_base_next  = pend_base_reg;
        word_next       = word_reg;
        onehot_next     = onehot_reg;
        idx_next        = idx_reg;
        fp_next         = fp_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_page_next     = m_page_reg;
        m_count_next    = m_count_reg;
        ffp_next        = ffp_reg;
        inst_next       = inst_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = w_reg;
        mem_wd          = '0;

        // Configuration writes; indexes past the list are ignored.
        if (cfg_valid) begin
            if (cfg_index == CFG_FIRST_FREE) begin
                ffp_next = cfg_data;
            end else if (cfg_index == CFG_INSTALLED) begin
                inst_next = cfg_data;
            end
        end

        unique case (state_reg)
            // Write every word: zeros after reset, the init pattern for init.
            FSM_SWEEP: begin
                mem_we = 1'b1;
                mem_wd = sweep_init_reg ? init_mask : '0;
                if (w_reg == LAST_W) begin
                    w_next    = '0;
                    base_next = '0;
                    if (sweep_init_reg) begin
                        cnt_next        = init_cnt;
                        res_status_next = ST_OK;
                        res_page_next   = '0;
                        state_next      = FSM_RESP;
                    end else begin
                        state_next = FSM_IDLE;
                    end
                end else begin
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + WB_X;
                end
            end

            FSM_IDLE: begin
                w_next    = '0;
                base_next = '0;
                pend_next = 1'b0;
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_INIT: begin
                            sweep_init_next = 1'b1;
                            state_next      = FSM_SWEEP;
                        end
                        OP_ALLOC: begin
                            state_next = FSM_SCAN;
                        end
                        OP_FREE: begin
                            fp_next = s_tdata[PAGE_W-1:0];
                            if (BW'(s_tdata[PAGE_W-1:0]) >= PAGES_X) begin
                                res_status_next = ST_BADFREE;
                                res_page_next   = '0;
                                state_next      = FSM_RESP;
                            end else begin
                                state_next = FSM_SEEK;
                            end
                        end
                        default: begin
                            state_next = FSM_IDLE;
                        end
                    endcase
                end
            end

            // Read one word per cycle and test the word read in the cycle before.
            FSM_SCAN: begin
                if (pend_reg && (mem_rdata_reg != '0)) begin
                    word_next  = mem_rdata_reg;
                    state_next = FSM_PICK;
                end else if (pend_reg && (pend_w_reg == LAST_W)) begin
                    res_status_next = ST_EMPTY;
                    res_page_next   = '0;
                    state_next      = FSM_RESP;
                end else begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_w_next    = w_reg;
                    pend_base_next = base_reg;
                    if (w_reg != LAST_W) begin
                        w_next    = w_reg + AW'(1);
                        base_next = base_reg + WB_X;
                    end
                end
            end

            FSM_PICK: begin
                onehot_next = lb_onehot;
                idx_next    = lb_idx;
                state_next  = FSM_TAKE;
            end

            // Take the page unless it lies past the installed memory.
            FSM_TAKE: begin
                if ((take_page >= BW'(inst_reg)) || (take_page >= PAGES_X)) begin
                    res_status_next = ST_BEYOND;
                    res_page_next   = '0;
                end else begin
                    mem_we          = 1'b1;
                    mem_addr        = pend_w_reg;
                    mem_wd          = word_reg & ~onehot_reg;
                    cnt_next        = cnt_reg - CNT_BITS'(1);
                    res_status_next = ST_OK;
                    res_page_next   = take_page[PAGE_W-1:0];
                end
                state_next = FSM_RESP;
            end

            // Step word by word until the word holding the page is reached.
            FSM_SEEK: begin
                if (BW'(fp_reg) < (base_reg + WB_X)) begin
                    mem_re     = 1'b1;
                    state_next = FSM_FCHK;
                end else begin
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + WB_X;
                end
            end

            // A page that is already free is refused.
            FSM_FCHK: begin
                if (mem_rdata_reg[free_off]) begin
                    res_status_next = ST_BADFREE;
                end else begin
                    mem_we          = 1'b1;
                    mem_wd          = mem_rdata_reg | (WORD_BITS'(1) << free_off);
                    cnt_next        = cnt_reg + CNT_BITS'(1);
                    res_status_next = ST_OK;
                end
                res_page_next = '0;
                state_next    = FSM_RESP;
            end

            // Hand the result to the output register once it is free.
            FSM_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_page_next   = res_page_reg;
                    m_count_next  = cnt_x[COUNT_W-1:0];
                    state_next    = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg          <= '0;
            base_reg       <= '0;
            sweep_init_reg <= 1'b0;
            pend_reg       <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            ffp_reg        <= FIRST_FREE_RST;
            inst_reg       <= INSTALLED_RST;
        end else begin
            w_reg          <= w_next;
            base_reg       <= base_next;
            sweep_init_reg <= sweep_init_next;
            pend_reg       <= pend_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            ffp_reg        <= ffp_next;
            inst_reg       <= inst_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_w_reg     <= pend_w_next;
        pend_base_reg  <= pend_base_next;
        word_reg       <= word_next;
        onehot_reg     <= onehot_next;
        idx_reg        <= idx_next;
        fp_reg         <= fp_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        m_status_reg   <= m_status_next;
        m_page_reg     <= m_page_next;
        m_count_reg    <= m_count_next;
    end

`ifndef SYNTHESIS
    // A new result only appears when the controller leaves its response state.
    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == FSM_RESP))
        else $error("result raised outside the response state");

    // The free count never exceeds the number of pages.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_BITS'(PAGES))
        else $error("free count above page total");

    // The single memory port never reads and writes in the same cycle.
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("memory read and write in one cycle");
`endif

endmodule

// ----- rtl/core/bpfa_lowbit.sv -----
// Lowest-set-bit finder for one bitmap word.
// Gives the isolated lowest set bit and its position; no package needed.
module bpfa_lowbit #(
    parameter int WORD_BITS = 32,
    parameter int OB        = 5
) (
    input  logic [WORD_BITS-1:0] word,
    output logic [WORD_BITS-1:0] onehot,
    output logic [OB-1:0]        idx
);

    // Two's complement trick keeps only the lowest set bit.
    assign onehot = word & (~word + WORD_BITS'(1));

    // Each position bit is the OR of the one-hot bits whose index has that bit set.
    always_comb begin
        idx = '0;
        for (int k = 0; k < OB; k++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (((j >> k) & 1) == 1) begin
                    idx[k] = idx[k] | onehot[j];
                end
            end
        end
    end

endmodule

// ----- dv/tb_bitmap_page_frame_allocator.sv -----
// Self-checking testbench for the bitmap page frame allocator: directed and random commands
// are checked against a bit-accurate page map kept in the bench, under several configurations.
// Depends on bpfa_pkg and the bitmap_page_frame_allocator top level.
module tb_bitmap_page_frame_allocator;
    import bpfa_pkg::*;

    localparam int PAGES       = PAGES_DEF;
    localparam int WATCHDOG    = 3000;
    localparam int SETTLE      = 40;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 10;

    // Opcode value that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] pg;
    } page_cmd_t;

    typedef struct packed {
        status_t            st;
        logic [PAGE_W-1:0]  pg;
        logic [COUNT_W-1:0] cnt;
    } page_rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Commands waiting to be driven and responses waiting to arrive.
    page_cmd_t cmd_backlog[$];
    page_rsp_t due_responses[$];

    // Shadow of the allocator state and its registers.
    logic [PAGES-1:0] page_free_map = '0;
    logic [COUNT_W-1:0] free_total = '0;
    logic [CFG_W-1:0] first_free_cfg = FIRST_FREE_RST;
    logic [CFG_W-1:0] installed_cfg = INSTALLED_RST;

    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    bit s_acc = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int responses_seen = 0;
    int cmds_sent = 0;
    int status_hits[4] = '{0, 0, 0, 0};

    bitmap_page_frame_allocator dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Applies one command to the shadow page map; returns 1 when a response is due.
    function automatic bit apply_page_cmd(input page_cmd_t c, output page_rsp_t r);
        int i;
        int lowest;
        r = '{st: ST_OK, pg: '0, cnt: '0};
        lowest = -1;
        case (c.op)
            OP_INIT: begin
                page_free_map = '0;
                for (i = int'(first_free_cfg); i < PAGES; i++) begin
                    page_free_map[i] = 1'b1;
                end
                free_total = (first_free_cfg < PAGES) ? COUNT_W'(PAGES - first_free_cfg) : '0;
            end
            OP_ALLOC: begin
                for (i = 0; i < PAGES; i++) begin
                    if (lowest < 0 && page_free_map[i]) begin
                        lowest = i;
                    end
                end
                if (lowest < 0) begin
                    r.st = ST_EMPTY;
                end else if (lowest >= int'(installed_cfg)) begin
                    r.st = ST_BEYOND;
                end else begin
                    page_free_map[lowest] = 1'b0;
                    free_total = free_total - 1'b1;
                    r.pg = PAGE_W'(lowest);
                end
            end
            OP_FREE: begin
                if (page_free_map[c.pg]) begin
                    r.st = ST_BADFREE;
                end else begin
                    page_free_map[c.pg] = 1'b1;
                    free_total = free_total + 1'b1;
                end
            end
            default: return 1'b0;
        endcase
        r.cnt = free_total;
        return 1'b1;
    endfunction

    // Command driver: holds each transaction until accepted, with random gaps.
    always @(negedge aclk) begin
        page_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_acc) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_backlog.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                c = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= c.op;
                s_tdata <= {{(S_TDATA_W - PAGE_W){1'b0}}, c.pg};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Response sink: random stalls plus one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks responses, predicts accepted commands, tracks register writes.
    always @(posedge aclk) begin
        page_rsp_t want;
        page_rsp_t got;
        page_cmd_t c;
        bit busy;
        busy = 1'b0;
        s_acc <= s_tvalid && s_tready;
        if (m_tvalid && m_tready) begin
            busy = 1'b1;
            got = '{st: status_t'(m_tuser), pg: m_tdata[PAGE_W-1:0],
                    cnt: m_tdata[PAGE_W +: COUNT_W]};
            responses_seen++;
            status_hits[got.st]++;
            if (due_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected response: status %0d page %0d count %0d",
                             got.st, got.pg, got.cnt);
                end
            end else begin
                want = due_responses.pop_front();
                if (want != got) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected status %0d page %0d count %0d, got %0d %0d %0d",
                                 want.st, want.pg, want.cnt, got.st, got.pg, got.cnt);
                    end
                end
            end
        end
        if (s_tvalid && s_tready) begin
            busy = 1'b1;
            c = '{op: s_tuser, pg: s_tdata[PAGE_W-1:0]};
            cmds_sent++;
            if (apply_page_cmd(c, want)) begin
                due_responses.push_back(want);
            end
        end
        if (cfg_valid && cfg_ready) begin
            busy = 1'b1;
            case (cfg_index)
                CFG_FIRST_FREE: first_free_cfg = cfg_data;
                CFG_INSTALLED:  installed_cfg = cfg_data;
                default: ;
            endcase
        end
        quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb_bitmap_page_frame_allocator: done, errors");
            $finish;
        end
    end

    // One register write; leaves cfg_valid high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] first_free, input logic [CFG_W-1:0] installed);
        write_reg(CFG_FIRST_FREE, first_free);
        write_reg(CFG_INSTALLED, installed);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every command is out and answered, then lets the block settle.
    task automatic drain();
        while (!(cmd_backlog.size() == 0 && !s_tvalid && due_responses.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_cmd(input logic [OP_W-1:0] op, input int pg);
        cmd_backlog.push_back('{op: op, pg: PAGE_W'(pg)});
    endtask

    // Random mix of mostly alloc and free, with frees aimed near pages likely taken.
    task automatic push_random_mix(input int count, input int first_free);
        int done;
        int pick;
        int reach;
        done = 0;
        reach = (first_free + 40 > PAGES - 1) ? PAGES - 1 : first_free + 40;
        push_cmd(OP_INIT, $urandom_range(0, PAGES - 1));
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                push_cmd(OP_ALLOC, $urandom_range(0, PAGES - 1));
            end else if (pick < 90) begin
                case ($urandom_range(0, 3))
                    0, 1: push_cmd(OP_FREE, $urandom_range(0, reach));
                    2: push_cmd(OP_FREE, $urandom_range(0, PAGES - 1));
                    default: push_cmd(OP_FREE, $urandom_range(0, 31));
                endcase
            end else if (pick < 95) begin
                push_cmd(OP_INIT, $urandom_range(0, PAGES - 1));
            end else begin
                push_cmd(OP_UNUSED, $urandom_range(0, PAGES - 1));
                done--;
            end
            done++;
        end
    endtask

    initial begin
        int ph;
        int ff;
        int inst;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty map after reset, repeat free, unused opcode, default registers.
        push_cmd(OP_ALLOC, 0);
        push_cmd(OP_FREE, 0);
        push_cmd(OP_FREE, 0);
        push_cmd(OP_ALLOC, 511);
        push_cmd(OP_ALLOC, 0);
        push_cmd(OP_FREE, 511);
        push_cmd(OP_UNUSED, 511);
        push_cmd(OP_ALLOC, 0);
        push_cmd(OP_INIT, 0);
        push_cmd(OP_ALLOC, 0);
        push_cmd(OP_FREE, 0);
        push_cmd(OP_FREE, 511);
        drain();

        // First free page past the end: init frees nothing.
        set_config(10'd512, 10'd512);
        push_cmd(OP_INIT, 0);
        push_cmd(OP_ALLOC, 0);
        drain();

        // No installed memory: a found page is always beyond it.
        set_config(10'd100, 10'd0);
        push_cmd(OP_INIT, 0);
        push_cmd(OP_ALLOC, 0);
        drain();

        // Lowest free page not installed after a few allocations.
        set_config(10'd500, 10'd505);
        push_cmd(OP_INIT, 0);
        repeat (6) push_cmd(OP_ALLOC, 0);
        push_cmd(OP_FREE, 3);
        push_cmd(OP_ALLOC, 0);
        drain();

        // Random phases, each under its own register setting.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin ff = $urandom_range(0, 63); inst = 512; end
                1: begin ff = $urandom_range(0, 511); inst = $urandom_range(1, 512); end
                2: begin ff = $urandom_range(480, 512); inst = 512; end
                3: begin ff = 0; inst = $urandom_range(1, 40); end
                4: begin
                    ff = $urandom_range(0, 200);
                    inst = ff + $urandom_range(0, 20);
                end
                default: begin ff = $urandom_range(0, 100); inst = 512; idle_on = 1'b0; end
            endcase
            set_config(CFG_W'(ff), CFG_W'(inst));
            push_random_mix(100, ff);
            // Block the response side for a long stretch while commands keep coming.
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            drain();
        end

        $display("Ran %0d commands through directed and random phases, %0d responses checked.",
                 cmds_sent, responses_seen);
        $display("Status mix: ok %0d, empty %0d, beyond memory %0d, bad free %0d.",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_BEYOND],
                 status_hits[ST_BADFREE]);
        if (mismatches == 0 && due_responses.size() == 0) begin
            $display("tb_bitmap_page_frame_allocator: done, clean");
        end else begin
            $display("tb_bitmap_page_frame_allocator: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_lowbit.sv
rtl/core/bitmap_page_frame_allocator.sv
dv/tb_bitmap_page_frame_allocator.sv
